@@ src/box_average_downsample_defines.svh @@
// assertion macros used by the box average downsampler controller
`ifndef BOX_AVERAGE_DOWNSAMPLE_DEFINES_SVH
`define BOX_AVERAGE_DOWNSAMPLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BXA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box average assertion failed");

// next-cycle implication, disabled while in reset
`define BXA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box average assertion failed");

`endif

@@ src/bxavg_pkg.sv @@
// shared constants, register codes and controller/datapath interface types
package bxavg_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_FACTOR = 16;
    localparam int ROW_LIMIT  = 1024;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int FACTOR_W  = 5;
    localparam int IDX_W     = 2;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_W     = $clog2(ROW_LIMIT);
    localparam int PHASE_W   = $clog2(MAX_FACTOR);
    localparam int RUN_W     = PIX_W + PHASE_W;
    localparam int SUM_W     = PIX_W + 2 * PHASE_W;
    localparam int NUM_W     = SUM_W + 1;
    localparam int FF_W      = 2 * PHASE_W + 1;
    localparam int DIV_STEPS = PIX_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_W-1:0]    COLS_RESET   = CFG_W'(1024);
    localparam logic [CFG_W-1:0]    ROWS_RESET   = CFG_W'(1024);
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);

    localparam logic [IDX_W-1:0] CFG_IMAGE_COLS = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_IMAGE_ROWS = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_FACTOR     = IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_DIV  = 3'b100
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic need_load;
        logic pend_emit;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

@@ src/bxavg_ctrl.sv @@
// controller: sequences pixel acceptance, line store update, divide and result hand-off
`include "box_average_downsample_defines.svh"

module bxavg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bxavg_pkg::status_t status,
    output bxavg_pkg::cmd_t    cmd
);
    import bxavg_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.need_load)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                state_next = status.pend_emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                // hold the quotient until the output register is free
                if (status.div_done && !status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BXA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !status.out_busy)
    `BXA_ASSERT_NOW(a_load_after_accept, cmd.load, $past(cmd.accept))
    `BXA_ASSERT_NOW(a_result_after_div, cmd.out_load, status.div_done)
    `BXA_ASSERT_NEXT(a_div_holds, (state_reg == ST_DIV) && !status.div_done, state_reg == ST_DIV)

endmodule

@@ src/bxavg_datapath.sv @@
// datapath: frame position, line store of column sums, rounding divider, output register
module bxavg_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bxavg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bxavg_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [bxavg_pkg::PIX_W-1:0]    pixel,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [bxavg_pkg::PIX_W-1:0]    average,
    output logic                           frame_last,
    input  bxavg_pkg::cmd_t                cmd,
    output bxavg_pkg::status_t             status
);
    import bxavg_pkg::*;

    // configuration
    logic [CFG_W-1:0]    cols_reg;
    logic [CFG_W-1:0]    rows_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                restart;

    // frame position
    logic [COL_W-1:0]   col_count_reg, col_count_next;
    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic [PHASE_W-1:0] col_phase_reg, col_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [COL_W-1:0]   block_col_reg, block_col_next;
    logic [COL_W-1:0]   col_start_reg, col_start_next;
    logic [ROW_W-1:0]   row_start_reg, row_start_next;
    logic [RUN_W-1:0]   run_sum_reg, run_sum_next;

    // pending segment for the load cycle
    logic [RUN_W-1:0] pend_run_reg;
    logic [COL_W-1:0] pend_col_reg;
    logic             pend_mem_reg;
    logic             pend_emit_reg;
    logic             pend_last_reg;

    // line store
    logic [SUM_W-1:0] mem [MAX_COLS];
    logic [SUM_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [COL_W-1:0] mem_wa;
    logic [SUM_W-1:0] mem_wd;

    // divider
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [PIX_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] average_reg;
    logic             frame_last_reg;

    // effective settings
    logic [FACTOR_W-1:0] f_eff;
    logic [CFG_W-1:0]    cols_eff;
    logic [CFG_W-1:0]    rows_eff;
    logic [PHASE_W-1:0]  fm1;
    logic [FF_W-1:0]     ff;
    logic [CFG_W:0]      col_end;
    logic [CFG_W:0]      row_end;
    logic                col_whole, row_whole, col_last_blk, row_last_blk;
    logic                active, seg_end, row_first, row_final;
    logic                col_last, row_last;
    logic                direct_write;
    logic [RUN_W-1:0]    run_val;
    logic [NUM_W-1:0]    total;
    logic [NUM_W-1:0]    numer;

    always_comb
    begin
        priority if (factor_reg == '0)
            f_eff = FACTOR_W'(1);
        else if (factor_reg > FACTOR_W'(MAX_FACTOR))
            f_eff = FACTOR_W'(MAX_FACTOR);
        else
            f_eff = factor_reg;
        priority if (cols_reg == '0)
            cols_eff = CFG_W'(1);
        else if (cols_reg > CFG_W'(MAX_COLS))
            cols_eff = CFG_W'(MAX_COLS);
        else
            cols_eff = cols_reg;
        priority if (rows_reg == '0)
            rows_eff = CFG_W'(1);
        else if (rows_reg > CFG_W'(ROW_LIMIT))
            rows_eff = CFG_W'(ROW_LIMIT);
        else
            rows_eff = rows_reg;
    end

    assign fm1 = PHASE_W'(f_eff - FACTOR_W'(1));
    assign ff  = FF_W'(f_eff * f_eff);

    // a block is whole when its far edge still lies inside the frame
    assign col_end      = (CFG_W + 1)'(col_start_reg) + (CFG_W + 1)'(f_eff);
    assign row_end      = (CFG_W + 1)'(row_start_reg) + (CFG_W + 1)'(f_eff);
    assign col_whole    = col_end <= (CFG_W + 1)'(cols_eff);
    assign row_whole    = row_end <= (CFG_W + 1)'(rows_eff);
    assign col_last_blk = (col_end + (CFG_W + 1)'(f_eff)) > (CFG_W + 1)'(cols_eff);
    assign row_last_blk = (row_end + (CFG_W + 1)'(f_eff)) > (CFG_W + 1)'(rows_eff);

    assign active    = col_whole && row_whole;
    assign seg_end   = col_phase_reg == fm1;
    assign row_first = row_phase_reg == '0;
    assign row_final = row_phase_reg == fm1;
    assign col_last  = (CFG_W'(col_count_reg) + CFG_W'(1)) == cols_eff;
    assign row_last  = (CFG_W'(row_count_reg) + CFG_W'(1)) == rows_eff;

    assign run_val = ((col_phase_reg == '0) ? '0 : run_sum_reg) + RUN_W'(pixel);

    assign direct_write = active && seg_end && row_first && !row_final;

    assign restart = cfg_wr_en && ((cfg_index == CFG_IMAGE_COLS) ||
                                   (cfg_index == CFG_IMAGE_ROWS) ||
                                   (cfg_index == CFG_FACTOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= COLS_RESET;
            rows_reg   <= ROWS_RESET;
            factor_reg <= FACTOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_COLS: cols_reg   <= cfg_wdata;
                CFG_IMAGE_ROWS: rows_reg   <= cfg_wdata;
                CFG_FACTOR:     factor_reg <= cfg_wdata[FACTOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        block_col_next = block_col_reg;
        col_start_next = col_start_reg;
        row_start_next = row_start_reg;
        run_sum_next   = run_sum_reg;
        if (restart)
        begin
            col_count_next = '0;
            row_count_next = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            block_col_next = '0;
            col_start_next = '0;
            row_start_next = '0;
            run_sum_next   = '0;
        end
        else if (cmd.accept)
        begin
            if (active)
            begin
                run_sum_next = seg_end ? '0 : run_val;
            end
            if (seg_end)
            begin
                col_phase_next = '0;
                block_col_next = block_col_reg + COL_W'(1);
                col_start_next = col_count_reg + COL_W'(1);
            end
            else
            begin
                col_phase_next = col_phase_reg + PHASE_W'(1);
            end
            col_count_next = col_count_reg + COL_W'(1);
            if (col_last)
            begin
                col_count_next = '0;
                col_phase_next = '0;
                block_col_next = '0;
                col_start_next = '0;
                run_sum_next   = '0;
                if (row_final)
                begin
                    row_phase_next = '0;
                    row_start_next = row_count_reg + ROW_W'(1);
                end
                else
                begin
                    row_phase_next = row_phase_reg + PHASE_W'(1);
                end
                row_count_next = row_count_reg + ROW_W'(1);
                if (row_last)
                begin
                    row_count_next = '0;
                    row_phase_next = '0;
                    row_start_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            block_col_reg <= '0;
            col_start_reg <= '0;
            row_start_reg <= '0;
            run_sum_reg   <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            block_col_reg <= block_col_next;
            col_start_reg <= col_start_next;
            row_start_reg <= row_start_next;
            run_sum_reg   <= run_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_run_reg  <= run_val;
            pend_col_reg  <= block_col_reg;
            pend_mem_reg  <= !row_first;
            pend_emit_reg <= row_final;
            pend_last_reg <= col_last_blk && row_last_blk;
        end
    end

    // segment total: stored column sum of earlier rows plus this row's run
    assign total = (pend_mem_reg ? NUM_W'(rd_data_reg) : '0) + NUM_W'(pend_run_reg);
    assign numer = NUM_W'({total[SUM_W-1:0], 1'b0}) + NUM_W'(ff);

    assign mem_we = (cmd.accept && direct_write) || (cmd.load && !pend_emit_reg);
    assign mem_wa = cmd.load ? pend_col_reg : block_col_reg;
    assign mem_wd = cmd.load ? total[SUM_W-1:0] : SUM_W'(run_val);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= mem[block_col_reg];
        end
    end

    // restoring divide by 2*f*f, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.load && pend_emit_reg)
        begin
            dcnt_reg <= DCNT_W'(DIV_STEPS);
        end
        else if (dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && pend_emit_reg)
        begin
            rem_reg <= numer;
            dsh_reg <= NUM_W'({ff, 1'b0}) << (DIV_STEPS - 1);
        end
        else if (dcnt_reg != '0)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[PIX_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[PIX_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            average_reg    <= quo_reg;
            frame_last_reg <= pend_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign frame_last = frame_last_reg;

    assign status.need_load = active && seg_end && (!row_first || row_final);
    assign status.pend_emit = pend_emit_reg;
    assign status.div_done  = dcnt_reg == '0;
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

@@ src/box_average_downsample.sv @@
// box average downsampler: a segment end in the first row of a block of factor 2 or more
// is written straight to the line store, and in a middle row of its block takes a load
// state (registered line store read, then add and write back); a pixel completing a block,
// every pixel with factor 1, gets its result through load, 8 restoring divider steps by
// 2*f*f and hand-off, with in_ready low throughout, the hand-off held while an earlier
// result is untaken; reset clears counters, restores default settings, not the store
module box_average_downsample (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bxavg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bxavg_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bxavg_pkg::PIX_W-1:0]    pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bxavg_pkg::PIX_W-1:0]    average,
    output logic                           frame_last
);
    import bxavg_pkg::*;

    cmd_t    cmd;
    status_t status;

    bxavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bxavg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pixel      (pixel),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .average    (average),
        .frame_last (frame_last),
        .cmd        (cmd),
        .status     (status)
    );

endmodule
